### rtl/core/ppls_pkg.sv
// shared types, widths and register codes for the projected point light shader
package ppls_pkg;

	// texture scale of the projected light spot
	localparam int UV_SCALE = 4096;

	// divider geometry
	localparam int NUM_W   = 64;
	localparam int DEN_W   = 64;
	localparam int QUO_W   = 16;
	localparam int DIV_LAT = QUO_W + 1;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_LIGHT_POS_X     = 3'd0,
		CFG_LIGHT_POS_Y     = 3'd1,
		CFG_LIGHT_POS_Z     = 3'd2,
		CFG_LIGHT_INTENSITY = 3'd3,
		CFG_LIGHT_RGB       = 3'd4,
		CFG_MESH_RGBA       = 3'd5
	} cfg_idx_t;

	// one vertex item
	typedef struct packed {
		logic signed [15:0] vert_x;
		logic signed [15:0] vert_y;
		logic signed [15:0] vert_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [15:0] tangent_x;
		logic signed [15:0] tangent_y;
		logic signed [15:0] tangent_z;
		logic               last_vertex;
	} vtx_t;

	// one shaded result item
	typedef struct packed {
		logic signed [15:0] tex_u;
		logic signed [15:0] tex_v;
		logic        [7:0]  out_red;
		logic        [7:0]  out_green;
		logic        [7:0]  out_blue;
		logic        [7:0]  out_alpha;
		logic               out_last;
	} res_t;

	// per item flags that ride alongside the dividers
	typedef struct packed {
		logic pos;
		logic big;
		logic su;
		logic sv;
		logic last;
	} side_t;

endpackage

### rtl/core/ppls_div.sv
// pipelined restoring divider: 16 quotient bits with an overflow flag
module ppls_div (
	input  logic                           clk,
	input  logic                           en,
	input  logic [ppls_pkg::NUM_W-1:0]     num,
	input  logic [ppls_pkg::DEN_W-1:0]     den,
	output logic [ppls_pkg::QUO_W-1:0]     quo,
	output logic                           ovf
);

	localparam int QW = ppls_pkg::QUO_W;
	localparam int CW = ppls_pkg::DEN_W + ppls_pkg::QUO_W;

	logic [ppls_pkg::NUM_W-1:0] rem_q [0:QW];
	logic [ppls_pkg::DEN_W-1:0] den_q [0:QW];
	logic [QW-1:0]              quo_q [0:QW];
	logic                       ovf_q [0:QW];

	// first stage: quotient too large for the result width
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= num;
			den_q[0] <= den;
			quo_q[0] <= '0;
			ovf_q[0] <= CW'(num) >= {den, {QW{1'b0}}};
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [CW-1:0] sh;
		logic          ge;

		assign sh = CW'(den_q[k-1]) << (QW - k);
		assign ge = CW'(rem_q[k-1]) >= sh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? rem_q[k-1] - sh[ppls_pkg::NUM_W-1:0] : rem_q[k-1];
				den_q[k] <= den_q[k-1];
				quo_q[k] <= quo_q[k-1] | (QW'(ge) << (QW - k));
				ovf_q[k] <= ovf_q[k-1];
			end
		end
	end

	assign quo = quo_q[QW];
	assign ovf = ovf_q[QW];

endmodule

### rtl/core/projected_point_light_vertex_shade_unit.sv
// Projected point light vertex shader. One vertex item enters per clock unless the pipe is held;
// its result passes six arithmetic stages, a 17-stage divider, three color stages and the output
// register; the length is set by the bit-per-stage long division of u, v and the
// attenuation. The whole pipeline holds while the output register holds a stalled item, so
// vtx_stall follows res_stall only then. Configuration writes are always taken (cfg_ready is
// high) and act on items still in flight, so write only when the block is empty.
module projected_point_light_vertex_shade_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vtx_valid,
	output logic                  vtx_stall,
	input  ppls_pkg::vtx_t        vtx,
	output logic                  res_valid,
	input  logic                  res_stall,
	output ppls_pkg::res_t        res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	localparam int PIPE = 6 + ppls_pkg::DIV_LAT + 3;
	localparam int DL   = ppls_pkg::DIV_LAT;
	localparam logic signed [15:0] UvScaleS = 16'(ppls_pkg::UV_SCALE);

	// configuration registers
	logic signed [15:0] light_pos_x_q, light_pos_y_q, light_pos_z_q;
	logic [31:0]        light_int_q;
	logic [23:0]        light_rgb_q;
	logic [31:0]        mesh_rgba_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_pos_x_q <= '0;
			light_pos_y_q <= '0;
			light_pos_z_q <= '0;
			light_int_q   <= '0;
			light_rgb_q   <= '0;
			mesh_rgba_q   <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ppls_pkg::CFG_LIGHT_POS_X:     light_pos_x_q <= cfg_data[15:0];
				ppls_pkg::CFG_LIGHT_POS_Y:     light_pos_y_q <= cfg_data[15:0];
				ppls_pkg::CFG_LIGHT_POS_Z:     light_pos_z_q <= cfg_data[15:0];
				ppls_pkg::CFG_LIGHT_INTENSITY: light_int_q   <= cfg_data;
				ppls_pkg::CFG_LIGHT_RGB:       light_rgb_q   <= cfg_data[23:0];
				ppls_pkg::CFG_MESH_RGBA:       mesh_rgba_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: the pipe moves unless the output item is held
	logic en;
	logic res_valid_q;
	logic [PIPE-1:0] pv_q;

	assign en        = !res_valid_q || !res_stall;
	assign vtx_stall = !en;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q        <= '0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			pv_q        <= {pv_q[PIPE-2:0], vtx_valid};
			res_valid_q <= pv_q[PIPE-1];
		end
	end

	// stage 1: light offset and raw cross product
	logic signed [16:0] dx, dy, dz;
	logic signed [32:0] crx, cry, crz;
	logic signed [16:0] dx_s1, dy_s1, dz_s1;
	logic signed [15:0] nx_s1, ny_s1, nz_s1, tx_s1, ty_s1, tz_s1;
	logic signed [32:0] crx_s1, cry_s1, crz_s1;
	logic               last_s1;

	always_comb begin
		dx  = {light_pos_x_q[15], light_pos_x_q} - {vtx.vert_x[15], vtx.vert_x};
		dy  = {light_pos_y_q[15], light_pos_y_q} - {vtx.vert_y[15], vtx.vert_y};
		dz  = {light_pos_z_q[15], light_pos_z_q} - {vtx.vert_z[15], vtx.vert_z};
		crx = vtx.normal_y * vtx.tangent_z - vtx.normal_z * vtx.tangent_y;
		cry = vtx.normal_z * vtx.tangent_x - vtx.normal_x * vtx.tangent_z;
		crz = vtx.normal_x * vtx.tangent_y - vtx.normal_y * vtx.tangent_x;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= dx;
			dy_s1   <= dy;
			dz_s1   <= dz;
			nx_s1   <= vtx.normal_x;
			ny_s1   <= vtx.normal_y;
			nz_s1   <= vtx.normal_z;
			tx_s1   <= vtx.tangent_x;
			ty_s1   <= vtx.tangent_y;
			tz_s1   <= vtx.tangent_z;
			crx_s1  <= crx;
			cry_s1  <= cry;
			crz_s1  <= crz;
			last_s1 <= vtx.last_vertex;
		end
	end

	// stage 2: rounded cotangent, normal and tangent distances
	logic signed [33:0] rx, ry, rz;
	logic signed [34:0] pd, td;
	logic signed [19:0] cx_s2, cy_s2, cz_s2;
	logic signed [16:0] dx_s2, dy_s2, dz_s2;
	logic signed [34:0] p_s2, t_s2;
	logic               last_s2;

	always_comb begin
		rx = crx_s1 + 34'sd8192;
		ry = cry_s1 + 34'sd8192;
		rz = crz_s1 + 34'sd8192;
		pd = nx_s1 * dx_s1 + ny_s1 * dy_s1 + nz_s1 * dz_s1;
		td = tx_s1 * dx_s1 + ty_s1 * dy_s1 + tz_s1 * dz_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s2   <= rx[33:14];
			cy_s2   <= ry[33:14];
			cz_s2   <= rz[33:14];
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			dz_s2   <= dz_s1;
			p_s2    <= pd;
			t_s2    <= td;
			last_s2 <= last_s1;
		end
	end

	// stage 3: cotangent distance
	logic signed [38:0] cd;
	logic signed [38:0] c_s3;
	logic signed [34:0] p_s3, t_s3;
	logic               last_s3;

	assign cd = cx_s2 * dx_s2 + cy_s2 * dy_s2 + cz_s2 * dz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3    <= cd;
			p_s3    <= p_s2;
			t_s3    <= t_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 4: numerator terms and squared normal distance
	logic signed [39:0] p40, eu, ev;
	logic signed [39:0] eu_s4, ev_s4;
	logic [63:0]        pp_s4;
	logic [34:0]        p_s4;
	logic               pos_s4, big_s4, last_s4;

	always_comb begin
		p40 = p_s3;
		eu  = (p40 <<< 2) - t_s3;
		ev  = (p40 <<< 2) - c_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eu_s4   <= eu;
			ev_s4   <= ev;
			pp_s4   <= p_s3[31:0] * p_s3[31:0];
			p_s4    <= p_s3;
			pos_s4  <= !p_s3[34] && (p_s3 != '0);
			big_s4  <= p_s3[34:32] != '0;
			last_s4 <= last_s3;
		end
	end

	// stage 5: scale numerators
	logic signed [55:0] nu, nv;
	logic signed [55:0] nu_s5, nv_s5;
	logic [63:0]        pp_s5;
	logic [34:0]        p_s5;
	logic               pos_s5, big_s5, last_s5;

	always_comb begin
		nu = eu_s4 * UvScaleS;
		nv = ev_s4 * UvScaleS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nu_s5   <= nu;
			nv_s5   <= nv;
			pp_s5   <= pp_s4;
			p_s5    <= p_s4;
			pos_s5  <= pos_s4;
			big_s5  <= big_s4;
			last_s5 <= last_s4;
		end
	end

	// stage 6: sign and magnitude for the dividers
	logic [55:0]     au_s6, av_s6;
	logic [63:0]     pp_s6, den_s6;
	ppls_pkg::side_t side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			au_s6        <= nu_s5[55] ? 56'(-nu_s5) : 56'(nu_s5);
			av_s6        <= nv_s5[55] ? 56'(-nv_s5) : 56'(nv_s5);
			pp_s6        <= pp_s5;
			den_s6       <= {26'b0, p_s5, 3'b0};
			side_s6.pos  <= pos_s5;
			side_s6.big  <= big_s5;
			side_s6.su   <= nu_s5[55];
			side_s6.sv   <= nv_s5[55];
			side_s6.last <= last_s5;
		end
	end

	// dividers for u, v and attenuation
	logic [15:0] qu, qv, qf;
	logic        ou, ov, of;

	ppls_div u_div_u (
		.clk (clk), .en (en), .num ({8'b0, au_s6}), .den (den_s6), .quo (qu), .ovf (ou)
	);

	ppls_div u_div_v (
		.clk (clk), .en (en), .num ({8'b0, av_s6}), .den (den_s6), .quo (qv), .ovf (ov)
	);

	ppls_div u_div_f (
		.clk (clk), .en (en), .num ({4'b0, light_int_q, 28'b0}), .den (pp_s6),
		.quo (qf), .ovf (of)
	);

	// flags delayed alongside the dividers
	ppls_pkg::side_t side_q [0:DL-1];

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s6;
			for (int i = 1; i < DL; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// attenuation limit table, 65280 over the brightest light channel
	logic [15:0] lim_tab [256];

	for (genvar g = 0; g < 256; g++) begin : g_lim
		localparam logic [15:0] LimVal = (g == 0) ? 16'hFFFF : 16'(65280 / (g + (g == 0)));
		assign lim_tab[g] = LimVal;
	end

	logic [7:0]  lr, lg, lb, chmax;
	logic [15:0] lim;

	always_comb begin
		lr    = light_rgb_q[23:16];
		lg    = light_rgb_q[15:8];
		lb    = light_rgb_q[7:0];
		chmax = (lr > lg) ? lr : lg;
		chmax = (lb > chmax) ? lb : chmax;
		lim   = (chmax == '0) ? 16'hFFFF : lim_tab[chmax];
	end

	// stage 7: signed saturation of u and v, clamped attenuation
	function automatic logic [15:0] sat_quo(input logic [15:0] q, input logic o,
		input logic s);
		logic [15:0] r;
		if (!s) begin
			r = (o || q[15]) ? 16'h7FFF : q;
		end else begin
			r = (o || q > 16'h8000) ? 16'h8000 : 16'(-q);
		end
		return r;
	endfunction

	ppls_pkg::side_t sd;
	logic [15:0]     u_s7, v_s7, f_s7;
	logic            last_s7;

	assign sd = side_q[DL-1];

	always_ff @(posedge clk) begin
		if (en) begin
			u_s7    <= sd.pos ? sat_quo(qu, ou, sd.su) : '0;
			v_s7    <= sd.pos ? sat_quo(qv, ov, sd.sv) : '0;
			if (!sd.pos || sd.big) begin
				f_s7 <= '0;
			end else if (of || qf > lim) begin
				f_s7 <= lim;
			end else begin
				f_s7 <= qf;
			end
			last_s7 <= sd.last;
		end
	end

	// stage 8: light color scaled by attenuation
	logic [23:0] sr, sg, sb;
	logic [7:0]  lr_s8, lg_s8, lb_s8;
	logic [15:0] u_s8, v_s8;
	logic        last_s8;

	always_comb begin
		sr = lr * f_s7;
		sg = lg * f_s7;
		sb = lb * f_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lr_s8   <= sr[15:8];
			lg_s8   <= sg[15:8];
			lb_s8   <= sb[15:8];
			u_s8    <= u_s7;
			v_s8    <= v_s7;
			last_s8 <= last_s7;
		end
	end

	// stage 9: modulate by mesh color with rounding bias
	logic [15:0] xr_s9, xg_s9, xb_s9;
	logic [15:0] u_s9, v_s9;
	logic        last_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			xr_s9   <= 16'(lr_s8) * 16'(mesh_rgba_q[31:24]) + 16'd127;
			xg_s9   <= 16'(lg_s8) * 16'(mesh_rgba_q[23:16]) + 16'd127;
			xb_s9   <= 16'(lb_s8) * 16'(mesh_rgba_q[15:8]) + 16'd127;
			u_s9    <= u_s8;
			v_s9    <= v_s8;
			last_s9 <= last_s8;
		end
	end

	// output register: divide by 255 as (x + 1 + x/256) / 256
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'd1 + 17'(x[15:8]);
		return t[15:8];
	endfunction

	ppls_pkg::res_t res_q;

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.tex_u     <= u_s9;
			res_q.tex_v     <= v_s9;
			res_q.out_red   <= div255(xr_s9);
			res_q.out_green <= div255(xg_s9);
			res_q.out_blue  <= div255(xb_s9);
			res_q.out_alpha <= mesh_rgba_q[7:0];
			res_q.out_last  <= last_s9;
		end
	end

	assign res = res_q;

endmodule

### rtl/core/ppls_chk.sv
// port level checks for the projected point light shader, bound to the top level
module ppls_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           vtx_stall,
	input logic           res_valid,
	input logic           res_stall,
	input ppls_pkg::res_t res,
	input logic           cfg_valid,
	input logic           cfg_ready,
	input logic [2:0]     cfg_index,
	input logic [31:0]    cfg_data
);

	// mesh alpha as last written through the configuration port
	logic [7:0] alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 8'hFF;
		end else if (cfg_valid && cfg_ready && cfg_index == ppls_pkg::CFG_MESH_RGBA) begin
			alpha_q <= cfg_data[7:0];
		end
	end

	// a held result item stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result item changed while stalled");

	// input stalls only behind a held result item
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_stall |-> res_valid && res_stall)
		else $error("input stalled without a held result item");

	// alpha follows the mesh color register
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.out_alpha == alpha_q)
		else $error("result alpha differs from mesh alpha");

endmodule

bind projected_point_light_vertex_shade_unit ppls_chk u_ppls_chk (.*);

### tb/ppls_checker.sv
// checker for the projected point light shader: watches the channels, predicts and compares
module ppls_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vtx_valid,
	input  logic             vtx_stall,
	input  ppls_pkg::vtx_t   vtx,
	input  logic             res_valid,
	input  logic             res_stall,
	input  ppls_pkg::res_t   res,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	output int               mismatch_count,
	output int               shades_pending
);
	import ppls_pkg::*;

	// light and mesh settings as the block should hold them
	logic signed [15:0] light_x, light_y, light_z;
	logic [31:0]        intensity;
	logic [23:0]        light_color;
	logic [31:0]        mesh_color;

	res_t expected_shades[$];

	assign shades_pending = expected_shades.size();

	// saturate to a signed 16 bit texture coordinate
	function automatic logic signed [15:0] clamp16(longint x);
		if (x > 32767)
			return 16'sd32767;
		if (x < -32768)
			return -16'sd32768;
		return x[15:0];
	endfunction

	// shading of one vertex under the current light
	function automatic res_t shade_vertex(vtx_t v);
		longint dx, dy, dz, nx, ny, nz, tx, ty, tz, cx, cy, cz, p, t, c, den, base;
		longint unsigned f, m, pp;
		longint unsigned lch[3];
		longint unsigned mch[3];
		longint unsigned och[3];
		res_t o;
		dx = longint'(light_x) - longint'(v.vert_x);
		dy = longint'(light_y) - longint'(v.vert_y);
		dz = longint'(light_z) - longint'(v.vert_z);
		nx = v.normal_x;
		ny = v.normal_y;
		nz = v.normal_z;
		tx = v.tangent_x;
		ty = v.tangent_y;
		tz = v.tangent_z;
		// cotangent is n x t, rounded back to Q1.14
		cx = (ny * tz - nz * ty + 8192) >>> 14;
		cy = (nz * tx - nx * tz + 8192) >>> 14;
		cz = (nx * ty - ny * tx + 8192) >>> 14;
		p = nx * dx + ny * dy + nz * dz;
		t = tx * dx + ty * dy + tz * dz;
		c = cx * dx + cy * dy + cz * dz;
		lch[0] = light_color[23:16];
		lch[1] = light_color[15:8];
		lch[2] = light_color[7:0];
		mch[0] = mesh_color[31:24];
		mch[1] = mesh_color[23:16];
		mch[2] = mesh_color[15:8];
		o = '0;
		if (p > 0) begin
			den = 8 * p;
			base = longint'(UV_SCALE) * 4 * p;
			o.tex_u = clamp16((base - longint'(UV_SCALE) * t) / den);
			o.tex_v = clamp16((base - longint'(UV_SCALE) * c) / den);
			// attenuation in Q8.8, zero when far away
			f = 0;
			if (p < 64'sh1_0000_0000) begin
				pp = longint'(p) * longint'(p);
				f = ({32'b0, intensity} << 28) / pp;
			end
			m = 65535;
			for (int i = 0; i < 3; i++)
				if (lch[i] != 0 && 65280 / lch[i] < m)
					m = 65280 / lch[i];
			if (f > m)
				f = m;
			for (int i = 0; i < 3; i++) begin
				och[i] = ((lch[i] * f) >> 8) & 255;
				och[i] = (och[i] * mch[i] + 127) / 255;
			end
			o.out_red = och[0][7:0];
			o.out_green = och[1][7:0];
			o.out_blue = och[2][7:0];
		end
		o.out_alpha = mesh_color[7:0];
		o.out_last = v.last_vertex;
		return o;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch on %s: got %0d, expected %0d", field, got, want);
		mismatch_count++;
	endtask

	// settings follow the write channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x = 0;
			light_y = 0;
			light_z = 0;
			intensity = 0;
			light_color = 0;
			mesh_color = 32'hFFFF_FFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LIGHT_POS_X:     light_x = cfg_data[15:0];
				CFG_LIGHT_POS_Y:     light_y = cfg_data[15:0];
				CFG_LIGHT_POS_Z:     light_z = cfg_data[15:0];
				CFG_LIGHT_INTENSITY: intensity = cfg_data;
				CFG_LIGHT_RGB:       light_color = cfg_data[23:0];
				CFG_MESH_RGBA:       mesh_color = cfg_data;
				default: ;
			endcase
		end
	end

	initial mismatch_count = 0;

	// predict on each accepted vertex, compare each accepted result
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (vtx_valid && !vtx_stall)
				expected_shades.push_back(shade_vertex(vtx));
			if (res_valid && !res_stall) begin
				if (expected_shades.size() == 0) begin
					report_mismatch("result item with nothing expected", 1, 0);
				end else begin
					want = expected_shades.pop_front();
					if (res.tex_u !== want.tex_u)
						report_mismatch("tex_u", res.tex_u, want.tex_u);
					if (res.tex_v !== want.tex_v)
						report_mismatch("tex_v", res.tex_v, want.tex_v);
					if (res.out_red !== want.out_red)
						report_mismatch("out_red", res.out_red, want.out_red);
					if (res.out_green !== want.out_green)
						report_mismatch("out_green", res.out_green, want.out_green);
					if (res.out_blue !== want.out_blue)
						report_mismatch("out_blue", res.out_blue, want.out_blue);
					if (res.out_alpha !== want.out_alpha)
						report_mismatch("out_alpha", res.out_alpha, want.out_alpha);
					if (res.out_last !== want.out_last)
						report_mismatch("out_last", res.out_last, want.out_last);
				end
			end
		end
	end

endmodule

### tb/tb_top.sv
// top of the projected point light shader testbench: clock, reset, stimulus and verdict
module tb_top;
	import ppls_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        vtx_valid;
	logic        vtx_stall;
	vtx_t        vtx;
	logic        res_valid;
	logic        res_stall;
	res_t        res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	int mismatch_count;
	int shades_pending;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	projected_point_light_vertex_shade_unit dut (
		.clk(clk), .arst_n(arst_n),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ppls_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatch_count(mismatch_count), .shades_pending(shades_pending)
	);

	// clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// receiver stalls at random
	always @(negedge clk)
		res_stall <= ($urandom_range(99) < recv_stall_pct);

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((vtx_valid && !vtx_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// present one vertex and hold it until taken
	task automatic send_vertex(vtx_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			vtx_valid <= 1'b0;
			@(negedge clk);
		end
		vtx <= v;
		vtx_valid <= 1'b1;
		do @(posedge clk); while (vtx_stall);
		@(negedge clk);
	endtask

	// wait for the pipeline to drain, then write one register
	task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
		vtx_valid <= 1'b0;
		while (shades_pending != 0)
			@(negedge clk);
		repeat (32) @(negedge clk);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_light(logic [15:0] x, logic [15:0] y, logic [15:0] z,
			logic [31:0] inten, logic [23:0] rgb, logic [31:0] mesh);
		write_reg(CFG_LIGHT_POS_X, {16'h0, x});
		write_reg(CFG_LIGHT_POS_Y, {16'h0, y});
		write_reg(CFG_LIGHT_POS_Z, {16'h0, z});
		write_reg(CFG_LIGHT_INTENSITY, inten);
		write_reg(CFG_LIGHT_RGB, {8'h0, rgb});
		write_reg(CFG_MESH_RGBA, mesh);
	endtask

	function automatic logic [15:0] unit_comp();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	// random vertex: mostly unit range, some axis aligned near the origin, some raw bits
	function automatic vtx_t random_vertex();
		vtx_t v;
		int kind;
		int ax;
		v = '0;
		v.vert_x = 16'($urandom);
		v.vert_y = 16'($urandom);
		v.vert_z = 16'($urandom);
		v.last_vertex = 1'($urandom_range(1));
		kind = $urandom_range(9);
		if (kind < 6) begin
			v.normal_x = unit_comp();
			v.normal_y = unit_comp();
			v.normal_z = unit_comp();
			v.tangent_x = unit_comp();
			v.tangent_y = unit_comp();
			v.tangent_z = unit_comp();
		end else if (kind < 8) begin
			ax = $urandom_range(2);
			v.normal_x = (ax == 0) ? 16'sd16384 : 16'sd0;
			v.normal_y = (ax == 1) ? 16'sd16384 : 16'sd0;
			v.normal_z = (ax == 2) ? 16'sd16384 : 16'sd0;
			v.tangent_x = (ax == 1) ? 16'sd16384 : 16'sd0;
			v.tangent_y = (ax == 2) ? -16'sd16384 : 16'sd0;
			v.tangent_z = (ax == 0) ? 16'sd16384 : 16'sd0;
			v.vert_x = 16'($signed($urandom_range(64)) - 32);
			v.vert_y = 16'($signed($urandom_range(64)) - 32);
			v.vert_z = 16'($signed($urandom_range(64)) - 32);
		end else begin
			v.normal_x = 16'($urandom);
			v.normal_y = 16'($urandom);
			v.normal_z = 16'($urandom);
			v.tangent_x = 16'($urandom);
			v.tangent_y = 16'($urandom);
			v.tangent_z = 16'($urandom);
		end
		return v;
	endfunction

	function automatic vtx_t make_vertex(int x, int y, int z, int nx, int ny, int nz,
			int tx, int ty, int tz, bit last);
		vtx_t v;
		v.vert_x = 16'(x);
		v.vert_y = 16'(y);
		v.vert_z = 16'(z);
		v.normal_x = 16'(nx);
		v.normal_y = 16'(ny);
		v.normal_z = 16'(nz);
		v.tangent_x = 16'(tx);
		v.tangent_y = 16'(ty);
		v.tangent_z = 16'(tz);
		v.last_vertex = last;
		return v;
	endfunction

	initial begin
		arst_n = 1'b0;
		vtx_valid = 1'b0;
		vtx = '0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 35;
		recv_stall_pct = 68;
		quiet_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: light at origin, no intensity, white mesh
		send_vertex(make_vertex(0, 0, -100, 0, 0, 16384, 16384, 0, 0, 0));
		send_vertex(make_vertex(5, 3, 1, 0, 0, 16384, 16384, 0, 0, 1));

		// bright light, then light behind, zero normal, zero distance
		set_light(16'd0, 16'd0, 16'd100, 32'h0001_0000, 24'hFF_80_01, 32'h80FF_40C3);
		send_vertex(make_vertex(0, 0, 0, 0, 0, 16384, 16384, 0, 0, 0));
		send_vertex(make_vertex(50, -20, 90, 0, 0, 16384, 16384, 0, 0, 1));
		send_vertex(make_vertex(0, 0, 0, 0, 0, -16384, 16384, 0, 0, 0));
		send_vertex(make_vertex(0, 0, 100, 0, 0, 16384, 0, 16384, 0, 0));
		send_vertex(make_vertex(0, 0, 0, 0, 0, 0, 16384, 0, 0, 1));
		send_vertex(make_vertex(-32768, 32767, 99, 0, 0, 16384, 0, 0, 16384, 0));
		send_vertex(make_vertex(0, 0, 0, -16384, 16384, 16384, -16384, -16384, 16384, 1));

		// extreme light position: huge distance with non-unit normal, and saturation
		set_light(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF, 24'hFF_FF_FF, 32'hFFFF_FFFF);
		send_vertex(make_vertex(-32768, -32768, -32768, 32767, 32767, 32767,
			-32768, 0, 32767, 0));
		send_vertex(make_vertex(-32768, -32768, -32768, 16384, 0, 0, 0, 16384, 0, 1));
		send_vertex(make_vertex(32766, 32767, 32767, 16384, 0, 0, 0, 16384, 16384, 0));
		send_vertex(make_vertex(32767, 32767, 32767, 16384, 16384, 16384,
			16384, 16384, 16384, 1));
		set_light(16'h8000, 16'h8000, 16'h8000, 32'h0, 24'h0, 32'h0);
		send_vertex(make_vertex(32767, 32767, 32767, -16384, -16384, -16384,
			16384, -16384, 0, 0));
		send_vertex(make_vertex(-32767, -32768, -32768, -16384, 0, 0, 0, 0, 16384, 1));

		// random phases under several light settings and idling modes
		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin send_idle_pct = 35; recv_stall_pct = 68; end
				1: begin send_idle_pct = 68; recv_stall_pct = 35; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			if (ph == 0)
				set_light(16'h7FFF, 16'h8000, 16'h0000, 32'hFFFF_FFFF, 24'hFF_FF_FF, 32'h0);
			else
				set_light(16'($signed($urandom_range(128)) - 64), 16'($urandom),
					16'($urandom_range(64)),
					$urandom_range(1) ? $urandom : $urandom_range(1 << 16),
					24'($urandom), $urandom);
			for (int i = 0; i < 65; i++)
				send_vertex(random_vertex());
		end
		vtx_valid <= 1'b0;

		while (shades_pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
